FILE: sv/rc4_stream_cipher_core_defines.svh
// ---------------------------------------------------------------------------
// RC4 stream cipher core: assertion macros
// Shared helpers that write clocked assertions on clk with a low rst_n
// disabling them.
// ---------------------------------------------------------------------------
`ifndef RC4_STREAM_CIPHER_CORE_DEFINES_SVH
`define RC4_STREAM_CIPHER_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RC4SC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RC4SC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/rc4sc_pkg.sv
// ---------------------------------------------------------------------------
// RC4 stream cipher package
// Widths, word mode codes, datapath command codes and the command and
// status structs shared by the controller and the datapath.
// ---------------------------------------------------------------------------
`default_nettype none

package rc4sc_pkg;

  localparam int unsigned KEY_DEPTH_DEF = 256;
  localparam int unsigned PERM_DEPTH    = 256;
  localparam int unsigned BYTE_W        = 8;

  localparam logic MODE_KEY  = 1'b0;
  localparam logic MODE_DATA = 1'b1;

  localparam int unsigned CMD_W = 4;
  typedef logic [CMD_W-1:0] cmd_op_t;

  localparam cmd_op_t CMD_NONE    = 4'd0;
  localparam cmd_op_t CMD_FILL    = 4'd1;
  localparam cmd_op_t CMD_KEY_WR  = 4'd2;
  localparam cmd_op_t CMD_KS_RD   = 4'd3;
  localparam cmd_op_t CMD_KS_J    = 4'd4;
  localparam cmd_op_t CMD_KS_SWAP = 4'd5;
  localparam cmd_op_t CMD_KS_END  = 4'd6;
  localparam cmd_op_t CMD_DT_RD   = 4'd7;
  localparam cmd_op_t CMD_DT_J    = 4'd8;
  localparam cmd_op_t CMD_DT_SWAP = 4'd9;
  localparam cmd_op_t CMD_DT_END  = 4'd10;

  typedef struct packed {
    cmd_op_t op;
    logic    sched_done;
  } dp_cmd_t;

  typedef struct packed {
    logic n_last;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

FILE: sv/rc4sc_if.sv
// ---------------------------------------------------------------------------
// RC4 stream cipher channel interfaces
// Valid/ready channels for input words and for result words.
// ---------------------------------------------------------------------------
`default_nettype none

interface rc4sc_in_if;
  import rc4sc_pkg::*;

  logic              valid;
  logic              ready;
  logic              mode;
  logic [BYTE_W-1:0] value;
  logic              key_last;

  modport source (output valid, output mode, output value, output key_last, input ready);
  modport sink (input valid, input mode, input value, input key_last, output ready);
endinterface

interface rc4sc_out_if;
  import rc4sc_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_out;

  modport source (output valid, output data_out, input ready);
  modport sink (input valid, input data_out, output ready);
endinterface

`default_nettype wire

FILE: sv/rc4_stream_cipher_core.sv
// ---------------------------------------------------------------------------
// RC4 stream cipher core
// Byte-wide RC4 engine: key words load the key store, the last key word
// runs the key schedule, and each data word is XORed with the keystream.
// ---------------------------------------------------------------------------
// Usage: words enter on in_ch (valid/ready). A key word has mode low, a data
// word has mode high; key_last on a key word starts key scheduling. Each
// data word gives one result word on out_ch; key words give none.
// The core stays ready after a key word that is not the last. A data word
// occupies the core for these steps, set by the permutation memory: read
// S[i], read S[j], write S[i] with the keystream read, then write S[j].
// The last step waits until the result register is free and loads the
// result word there. The last key word keeps in_ch.ready low while the
// core refills the identity permutation and runs 256 schedule rounds.
// After reset the core writes the identity permutation with in_ch.ready
// low. The result register holds one word; when out_ch is stalled with a
// word waiting, the core still accepts the next word and holds its last
// step until the register is free.
// ---------------------------------------------------------------------------
`default_nettype none
`include "rc4_stream_cipher_core_defines.svh"

module rc4_stream_cipher_core #(
  parameter int unsigned KEY_DEPTH = rc4sc_pkg::KEY_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  rc4sc_in_if.sink    in_ch,
  rc4sc_out_if.source out_ch
);
  import rc4sc_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  rc4sc_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_mode     (in_ch.mode),
    .in_key_last (in_ch.key_last),
    .status      (status),
    .in_ready    (in_ch.ready),
    .cmd         (cmd)
  );

  rc4sc_dpath #(
    .KEY_DEPTH (KEY_DEPTH)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .in_value  (in_ch.value),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .out_data  (out_ch.data_out)
  );

  `RC4SC_ASSERT_SAME(a_no_result_overwrite, cmd.op == CMD_DT_END, status.out_free, "result word overwritten while waiting")
  `RC4SC_ASSERT_SAME(a_sched_done_at_end, cmd.sched_done, (cmd.op == CMD_KS_END) && status.n_last, "key schedule ended early")
  `RC4SC_ASSERT_NEXT(a_data_follows_read, in_ch.valid && in_ch.ready && (in_ch.mode == MODE_DATA), cmd.op == CMD_DT_J, "data word step skipped")

endmodule

`default_nettype wire

FILE: sv/rc4sc_ctrl.sv
// ---------------------------------------------------------------------------
// RC4 stream cipher controller
// Sequences the permutation fill, the key scheduling rounds and the
// steps of each data word, and issues one datapath command per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module rc4sc_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic                   in_mode,
  input  logic                   in_key_last,
  input  rc4sc_pkg::dp_status_t  status,
  output logic                   in_ready,
  output rc4sc_pkg::dp_cmd_t     cmd
);
  import rc4sc_pkg::*;

  localparam logic [3:0] ST_RST_FILL = 4'd0;
  localparam logic [3:0] ST_IDLE     = 4'd1;
  localparam logic [3:0] ST_KS_FILL  = 4'd2;
  localparam logic [3:0] ST_KS_RD    = 4'd3;
  localparam logic [3:0] ST_KS_J     = 4'd4;
  localparam logic [3:0] ST_KS_SWAP  = 4'd5;
  localparam logic [3:0] ST_KS_END   = 4'd6;
  localparam logic [3:0] ST_DT_J     = 4'd7;
  localparam logic [3:0] ST_DT_SWAP  = 4'd8;
  localparam logic [3:0] ST_DT_END   = 4'd9;

  logic [3:0] state_r;
  logic [3:0] state_nxt;
  logic       accept;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt      = state_r;
    cmd.op         = CMD_NONE;
    cmd.sched_done = 1'b0;
    unique case (state_r)
      ST_RST_FILL: begin
        cmd.op = CMD_FILL;
        if (status.n_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          unique case (in_mode)
            MODE_DATA: begin
              cmd.op    = CMD_DT_RD;
              state_nxt = ST_DT_J;
            end
            MODE_KEY: begin
              cmd.op = CMD_KEY_WR;
              if (in_key_last) begin
                state_nxt = ST_KS_FILL;
              end
            end
          endcase
        end
      end
      ST_KS_FILL: begin
        cmd.op = CMD_FILL;
        if (status.n_last) begin
          state_nxt = ST_KS_RD;
        end
      end
      ST_KS_RD: begin
        cmd.op    = CMD_KS_RD;
        state_nxt = ST_KS_J;
      end
      ST_KS_J: begin
        cmd.op    = CMD_KS_J;
        state_nxt = ST_KS_SWAP;
      end
      ST_KS_SWAP: begin
        cmd.op    = CMD_KS_SWAP;
        state_nxt = ST_KS_END;
      end
      ST_KS_END: begin
        cmd.op         = CMD_KS_END;
        cmd.sched_done = status.n_last;
        state_nxt      = status.n_last ? ST_IDLE : ST_KS_RD;
      end
      ST_DT_J: begin
        cmd.op    = CMD_DT_J;
        state_nxt = ST_DT_SWAP;
      end
      ST_DT_SWAP: begin
        cmd.op    = CMD_DT_SWAP;
        state_nxt = ST_DT_END;
      end
      ST_DT_END: begin
        if (status.out_free) begin
          cmd.op    = CMD_DT_END;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_RST_FILL;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: sv/rc4sc_dpath.sv
// ---------------------------------------------------------------------------
// RC4 stream cipher datapath
// Permutation memory with one write and two registered read ports, the
// key store, the index registers and the result word register.
// ---------------------------------------------------------------------------
`default_nettype none

module rc4sc_dpath #(
  parameter int unsigned KEY_DEPTH = rc4sc_pkg::KEY_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  rc4sc_pkg::dp_cmd_t            cmd,
  output rc4sc_pkg::dp_status_t         status,
  input  logic [rc4sc_pkg::BYTE_W-1:0]  in_value,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [rc4sc_pkg::BYTE_W-1:0]  out_data
);
  import rc4sc_pkg::*;

  localparam int unsigned KIDX_W = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
  localparam int unsigned CNT_W  = $clog2(KEY_DEPTH + 1);

  logic [BYTE_W-1:0] perm_mem [PERM_DEPTH];
  logic [BYTE_W-1:0] key_mem  [KEY_DEPTH];

  logic [BYTE_W-1:0] n_r;
  logic [BYTE_W-1:0] i_r;
  logic [BYTE_W-1:0] j_r;
  logic [CNT_W-1:0]  key_count_r;
  logic [KIDX_W-1:0] kp_r;
  logic              out_valid_r;

  logic [BYTE_W-1:0] pa_rd_r;
  logic [BYTE_W-1:0] pb_rd_r;
  logic [BYTE_W-1:0] key_rd_r;
  logic [BYTE_W-1:0] value_r;
  logic [BYTE_W-1:0] sb_save_r;
  logic              hit_i_r;
  logic              hit_j_r;
  logic [BYTE_W-1:0] data_out_r;

  logic [BYTE_W-1:0] i_inc;
  logic [BYTE_W-1:0] j_ks;
  logic [BYTE_W-1:0] j_dt;
  logic [BYTE_W-1:0] t_sum;
  logic [BYTE_W-1:0] ra_a;
  logic [BYTE_W-1:0] ra_b;
  logic              rd_a_en;
  logic              rd_b_en;
  logic              we;
  logic [BYTE_W-1:0] wa;
  logic [BYTE_W-1:0] wd;
  logic [CNT_W-1:0]  key_len;
  logic              key_full;
  logic              kp_wrap;
  logic [BYTE_W-1:0] ks_byte;

  assign i_inc    = i_r + BYTE_W'(1);
  assign j_ks     = j_r + pa_rd_r + key_rd_r;
  assign j_dt     = j_r + pa_rd_r;
  assign t_sum    = pa_rd_r + pb_rd_r;
  assign key_len  = (key_count_r == '0) ? CNT_W'(1) : key_count_r;
  assign key_full = (key_count_r == CNT_W'(KEY_DEPTH));
  assign kp_wrap  = ((CNT_W'(kp_r) + CNT_W'(1)) == key_len);
  assign ks_byte  = hit_i_r ? sb_save_r : (hit_j_r ? pa_rd_r : pb_rd_r);

  assign rd_a_en = (cmd.op == CMD_KS_RD) || (cmd.op == CMD_DT_RD);
  assign ra_a    = (cmd.op == CMD_KS_RD) ? n_r : i_inc;
  assign rd_b_en = (cmd.op == CMD_KS_J) || (cmd.op == CMD_DT_J) || (cmd.op == CMD_DT_SWAP);

  always_comb begin
    case (cmd.op)
      CMD_KS_J: ra_b = j_ks;
      CMD_DT_J: ra_b = j_dt;
      default:  ra_b = t_sum;
    endcase
  end

  always_comb begin
    we = 1'b1;
    wa = n_r;
    wd = pb_rd_r;
    case (cmd.op)
      CMD_FILL: begin
        wa = n_r;
        wd = n_r;
      end
      CMD_KS_SWAP: begin
        wa = n_r;
        wd = pb_rd_r;
      end
      CMD_KS_END: begin
        wa = j_r;
        wd = pa_rd_r;
      end
      CMD_DT_SWAP: begin
        wa = i_r;
        wd = pb_rd_r;
      end
      CMD_DT_END: begin
        wa = j_r;
        wd = pa_rd_r;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      perm_mem[wa] <= wd;
    end
    if (rd_a_en) begin
      pa_rd_r <= perm_mem[ra_a];
    end
    if (rd_b_en) begin
      pb_rd_r <= perm_mem[ra_b];
    end
  end

  always_ff @(posedge clk) begin
    if ((cmd.op == CMD_KEY_WR) && !key_full) begin
      key_mem[key_count_r[KIDX_W-1:0]] <= in_value;
    end
    if (cmd.op == CMD_KS_RD) begin
      key_rd_r <= key_mem[kp_r];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == CMD_DT_RD) begin
      value_r <= in_value;
    end
    if (cmd.op == CMD_DT_SWAP) begin
      sb_save_r <= pb_rd_r;
      hit_i_r   <= (t_sum == i_r);
      hit_j_r   <= (t_sum == j_r);
    end
    if (cmd.op == CMD_DT_END) begin
      data_out_r <= value_r ^ ks_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r         <= '0;
      i_r         <= '0;
      j_r         <= '0;
      key_count_r <= '0;
      kp_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      case (cmd.op)
        CMD_FILL: begin
          n_r <= n_r + BYTE_W'(1);
          i_r <= '0;
          j_r <= '0;
        end
        CMD_KEY_WR: begin
          if (!key_full) begin
            key_count_r <= key_count_r + CNT_W'(1);
          end
        end
        CMD_KS_J: begin
          j_r <= j_ks;
        end
        CMD_KS_END: begin
          n_r  <= n_r + BYTE_W'(1);
          kp_r <= (kp_wrap || cmd.sched_done) ? '0 : kp_r + KIDX_W'(1);
          if (cmd.sched_done) begin
            j_r         <= '0;
            key_count_r <= '0;
          end
        end
        CMD_DT_RD: begin
          i_r <= i_inc;
        end
        CMD_DT_J: begin
          j_r <= j_dt;
        end
        default: begin
        end
      endcase
      if (cmd.op == CMD_DT_END) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign status.n_last   = (n_r == {BYTE_W{1'b1}});
  assign status.out_free = !out_valid_r || out_ready;
  assign out_valid       = out_valid_r;
  assign out_data        = data_out_r;

endmodule

`default_nettype wire

FILE: verif/rc4_stream_cipher_core_tb.sv
// ---------------------------------------------------------------------------
// RC4 stream cipher core testbench
// Drives key words and data words into the core with random gaps on both
// channels and checks every result word against a software copy of the
// cipher state. A short directed part covers data before any key, one-byte
// keys, extreme byte values and a flagged data word. The random part covers
// well-formed keys followed by data, keys of exactly and beyond the key
// depth, unfinished keys and stray data words. One long receiver hold-off
// makes the core fill up and stall its input.
// ---------------------------------------------------------------------------
`default_nettype none

module rc4_stream_cipher_core_tb;
  import rc4sc_pkg::*;

  localparam int unsigned QUIET_LIMIT  = 20000;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned RANDOM_ITEMS = 1380;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned REPORT_MAX   = 10;

  class rc4_cipher_scoreboard;
    logic [BYTE_W-1:0] perm [PERM_DEPTH];
    logic [BYTE_W-1:0] key_bytes [KEY_DEPTH_DEF];
    int unsigned key_len;
    logic [BYTE_W-1:0] idx_i;
    logic [BYTE_W-1:0] idx_j;
    logic [BYTE_W-1:0] expected_bytes [$];
    int unsigned error_count;

    function new();
      for (int n = 0; n < PERM_DEPTH; n++) begin
        perm[n] = n[BYTE_W-1:0];
        key_bytes[n] = '0;
      end
      key_len = 0;
      idx_i = '0;
      idx_j = '0;
      error_count = 0;
    endfunction

    function void flag(string what, logic [BYTE_W-1:0] want, logic [BYTE_W-1:0] got);
      error_count++;
      if (error_count <= REPORT_MAX) begin
        $display("ERROR at %0t: %s: expected %02h, got %02h", $time, what, want, got);
      end
    endfunction

    function void run_key_schedule();
      int unsigned len;
      logic [BYTE_W-1:0] jj;
      logic [BYTE_W-1:0] t;
      len = (key_len == 0) ? 1 : key_len;
      for (int n = 0; n < PERM_DEPTH; n++) begin
        perm[n] = n[BYTE_W-1:0];
      end
      jj = '0;
      for (int n = 0; n < PERM_DEPTH; n++) begin
        jj = jj + perm[n] + key_bytes[n % len];
        t = perm[n];
        perm[n] = perm[jj];
        perm[jj] = t;
      end
      idx_i = '0;
      idx_j = '0;
      key_len = 0;
    endfunction

    function void note_word(logic mode, logic [BYTE_W-1:0] value, logic last);
      logic [BYTE_W-1:0] t;
      if (mode == MODE_KEY) begin
        if (key_len < KEY_DEPTH_DEF) begin
          key_bytes[key_len] = value;
          key_len++;
        end
        if (last) begin
          run_key_schedule();
        end
      end else begin
        idx_i = idx_i + 8'd1;
        idx_j = idx_j + perm[idx_i];
        t = perm[idx_i];
        perm[idx_i] = perm[idx_j];
        perm[idx_j] = t;
        t = perm[idx_i] + perm[idx_j];
        expected_bytes.push_back(value ^ perm[t]);
      end
    endfunction

    function void check_byte(logic [BYTE_W-1:0] got);
      logic [BYTE_W-1:0] want;
      if (expected_bytes.size() == 0) begin
        flag("result word with no data word pending", 'x, got);
      end else begin
        want = expected_bytes.pop_front();
        if (got !== want) begin
          flag("data_out mismatch", want, got);
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  int unsigned quiet_cycles;
  bit no_idle;
  bit hold_req;
  bit hold_done;
  rc4_cipher_scoreboard board;

  rc4sc_in_if  in_ch ();
  rc4sc_out_if out_ch ();

  rc4_stream_cipher_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  initial begin
    clk = 1'b0;
  end

  always #10 clk = ~clk;

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end else if (r < 98) begin
      return $urandom_range(4, 10);
    end
    return $urandom_range(20, 60);
  endfunction

  task automatic send_word(logic mode, logic [BYTE_W-1:0] value, logic last);
    int unsigned gap;
    gap = no_idle ? 0 : pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.mode     <= mode;
    in_ch.value    <= value;
    in_ch.key_last <= last;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    board.note_word(mode, value, last);
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      board.check_byte(out_ch.data_out);
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
        (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : watchdog
    quiet_cycles = 0;
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("rc4_stream_cipher_core_tb: FAIL");
    $finish;
  end

  initial begin : result_sink
    int unsigned stall;
    stall = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_done = 1'b1;
      end else if (stall > 0) begin
        out_ch.ready <= 1'b0;
        stall--;
      end else if (no_idle) begin
        out_ch.ready <= 1'b1;
      end else begin
        stall = pick_gap();
        out_ch.ready <= (stall == 0);
        if (stall > 0) begin
          stall--;
        end
      end
    end
  end

  initial begin : word_source
    int unsigned items;
    int unsigned seq;
    int unsigned kind;
    int unsigned key_n;
    int unsigned data_n;
    int unsigned r;
    board = new();
    no_idle = 1'b0;
    hold_req = 1'b0;
    hold_done = 1'b0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.mode = MODE_KEY;
    in_ch.value = '0;
    in_ch.key_last = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Data before any key runs on the identity permutation.
    send_word(MODE_DATA, 8'h00, 1'b0);
    send_word(MODE_DATA, 8'hFF, 1'b0);
    send_word(MODE_DATA, 8'hA5, 1'b1);
    send_word(MODE_KEY,  8'h00, 1'b1);
    send_word(MODE_DATA, 8'h5A, 1'b0);
    send_word(MODE_DATA, 8'hFF, 1'b0);
    send_word(MODE_KEY,  8'hFF, 1'b1);
    send_word(MODE_DATA, 8'h00, 1'b0);
    send_word(MODE_DATA, 8'h3C, 1'b1);
    send_word(MODE_KEY,  8'h01, 1'b0);
    send_word(MODE_KEY,  8'h80, 1'b0);
    send_word(MODE_KEY,  8'h7F, 1'b1);
    send_word(MODE_DATA, 8'h01, 1'b0);
    send_word(MODE_DATA, 8'h80, 1'b1);
    send_word(MODE_DATA, 8'h7F, 1'b0);

    items = 0;
    seq = 0;
    while (items < RANDOM_ITEMS) begin
      no_idle = (seq == 3) || ($urandom_range(0, 4) == 0);
      kind = (seq < 4) ? 9 : $urandom_range(0, 9);
      if (seq == 0) begin
        key_n = KEY_DEPTH_DEF;
      end else if (seq == 1) begin
        key_n = KEY_DEPTH_DEF + 44;
      end else if (kind == 0) begin
        key_n = $urandom_range(1, 8);
      end else if (kind == 1) begin
        key_n = 0;
      end else begin
        r = $urandom_range(0, 19);
        if (r < 14) begin
          key_n = $urandom_range(1, 16);
        end else if (r < 19) begin
          key_n = $urandom_range(17, 64);
        end else begin
          key_n = $urandom_range(65, 280);
        end
      end
      for (int k = 0; k < key_n; k++) begin
        send_word(MODE_KEY, 8'($urandom_range(0, 255)), (kind != 0) && (k == key_n - 1));
        items++;
      end
      data_n = (seq == 3) ? 40 : $urandom_range(1, 40);
      for (int k = 0; k < data_n; k++) begin
        if (seq == 3 && k == 1) begin
          hold_req = 1'b1;
        end
        send_word(MODE_DATA, 8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
        items++;
      end
      seq++;
    end

    in_ch.valid <= 1'b0;
    while (board.expected_bytes.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.expected_bytes.size() != 0) begin
      board.flag("result words never arrived", board.expected_bytes[0], 'x);
    end
    if (board.error_count == 0) begin
      $display("rc4_stream_cipher_core_tb: PASS");
    end else begin
      $display("rc4_stream_cipher_core_tb: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
